### rtl/bqpf_pkg.sv
// shared types and constants for the phone band filter
// no dependencies

package bqpf_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AccW     = 64;
  localparam int unsigned NumCells = 5;
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned GainW    = 16;
  localparam int unsigned TabW     = 31;

  typedef enum logic [2:0] {
    REG_HP     = 3'd0,
    REG_LP     = 3'd1,
    REG_PEAK_B = 3'd2,
    REG_PEAK_A = 3'd3,
    REG_DRIVE  = 3'd4,
    REG_BYPASS = 3'd5
  } reg_idx_e;

  // stage kinds of the cascade
  typedef enum logic [1:0] {
    KIND_HP   = 2'd0,
    KIND_LP   = 2'd1,
    KIND_PEAK = 2'd2
  } cell_kind_e;

  // control handed to every cell alongside its data
  typedef struct packed {
    logic clear;
    logic step;
  } cell_ctrl_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] max_v;
    logic signed [AccW-1:0] min_v;
    max_v = AccW'(64'sh0000_0000_7FFF_FFFF);
    min_v = -AccW'(64'sh0000_0000_8000_0000);
    if (v > max_v) begin
      return DataW'(32'sh7FFF_FFFF);
    end else if (v < min_v) begin
      return DataW'(32'sh8000_0000);
    end
    return v[DataW-1:0];
  endfunction

endpackage

### rtl/bqpf_if.sv
// valid/ready channel interface for the phone band filter
// depends on nothing

interface bqpf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               buffer_start;
  modport source (output valid, output sample_in, output buffer_start, input ready);
  modport sink   (input valid, input sample_in, input buffer_start, output ready);
endinterface

interface bqpf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/bqpf_cell.sv
// one direct form I biquad cell of the cascade, five multiply steps over a shared mac
// depends on bqpf_pkg

module bqpf_cell #(
  parameter int unsigned CoefBits = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bqpf_pkg::cell_ctrl_t                   ctrl_i,
  input  logic signed [bqpf_pkg::DataW-1:0]      x_i,
  input  logic signed [CoefBits-1:0]             b0_i,
  input  logic signed [CoefBits+1:0]             b1_i,
  input  logic signed [CoefBits-1:0]             b2_i,
  input  logic signed [CoefBits-1:0]             a1_i,
  input  logic signed [CoefBits-1:0]             a2_i,
  output logic signed [bqpf_pkg::DataW-1:0]      y_o,
  output logic                                   done_o
);

  localparam int unsigned FracBits = CoefBits - 2;
  localparam int unsigned W = bqpf_pkg::DataW;
  localparam int unsigned A = bqpf_pkg::AccW;

  logic signed [W-1:0] x1_q, x2_q, y1_q, y2_q, x_q, y_q;
  logic signed [A-1:0] acc_q, acc_d;
  logic [2:0]          phase_q;
  logic                busy_q, done_q;
  logic signed [CoefBits+1:0] coef;
  logic signed [W-1:0]        opnd;
  logic signed [A-1:0]        prod, rounded;

  // one product per phase
  always_comb begin
    case (phase_q)
      3'd0: begin coef = (CoefBits+2)'(b0_i); opnd = x_q;  end
      3'd1: begin coef = b1_i;                 opnd = x1_q; end
      3'd2: begin coef = (CoefBits+2)'(b2_i); opnd = x2_q; end
      3'd3: begin coef = -(CoefBits+2)'(a1_i); opnd = y1_q; end
      default: begin coef = -(CoefBits+2)'(a2_i); opnd = y2_q; end
    endcase
    prod    = A'(coef) * A'(opnd);
    acc_d   = acc_q + prod;
    rounded = (acc_q + (A'(1) <<< (FracBits-1))) >>> FracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0; x2_q <= '0; y1_q <= '0; y2_q <= '0;
      busy_q <= 1'b0; done_q <= 1'b0; phase_q <= '0;
      acc_q <= '0; x_q <= '0; y_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.clear) begin
        x1_q <= '0; x2_q <= '0; y1_q <= '0; y2_q <= '0;
      end
      if (ctrl_i.step) begin
        x_q     <= x_i;
        acc_q   <= '0;
        phase_q <= '0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        if (phase_q == 3'd5) begin
          y_q    <= bqpf_pkg::sat32(rounded);
          x2_q   <= x1_q; x1_q <= x_q;
          y2_q   <= y1_q; y1_q <= bqpf_pkg::sat32(rounded);
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          acc_q   <= acc_d;
          phase_q <= phase_q + 3'd1;
        end
      end
    end
  end

  assign y_o    = y_q;
  assign done_o = done_q;

endmodule

### rtl/bqpf_sat.sv
// drive gain and interpolated tanh saturator with rounding to int16
// depends on bqpf_pkg; tanh table built at elaboration

module bqpf_sat #(
  parameter int unsigned TanhEntries = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [bqpf_pkg::DataW-1:0] y_i,
  input  logic [bqpf_pkg::GainW-1:0]        gain_i,
  output logic signed [15:0]                out_o,
  output logic                              done_o
);

  localparam int unsigned IdxW = $clog2(TanhEntries);
  localparam int unsigned LogE = $clog2(TanhEntries);

  typedef logic [bqpf_pkg::TabW-1:0] rom_t [TanhEntries+1];

  // shift and subtract quotient, only evaluated while building the table
  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned q, rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem  = rem - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom();
    rom_t   t;
    longint unsigned h, term, r, e, den, num;
    h = (64'd16 << 31) >> LogE;
    term = 64'd1 << 31; r = 64'd1 << 31; e = 64'd1 << 31;
    for (int n = 1; n <= 8; n++) begin
      term = udiv((term * h) >> 31, 64'(n));
      if ((n & 1) == 1) r = r - term; else r = r + term;
    end
    for (int k = 0; k <= TanhEntries; k++) begin
      den  = (64'd1 << 31) + e;
      num  = ((64'd1 << 31) - e) << 30;
      t[k] = bqpf_pkg::TabW'(udiv(num + (den >> 1), den));
      e    = (e * r + (64'd1 << 30)) >> 31;
    end
    return t;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [2:0]  st_q;
  logic        neg_q, top_q;
  logic [47:0] mag_q;
  logic [IdxW-1:0] idx_q;
  logic [15:0] frac_q;
  logic [bqpf_pkg::TabW-1:0] lo_q, hi_q, t_q;
  logic [47:0] prod_q;
  logic [15:0] out_q;
  logic        done_q;
  logic signed [48:0] p;
  logic [47:0] pos;
  logic [47:0] scaled;

  assign p      = 49'(y_i) * 49'($signed({1'b0, gain_i}));
  // pos = m * entries >> 23, index from bit 16 up
  assign pos    = 48'(mag_q >> (23 - LogE));
  assign scaled = 48'(t_q) * 48'd32767 + (48'd1 << 29);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0; done_q <= 1'b0;
      neg_q <= 1'b0; top_q <= 1'b0; mag_q <= '0; idx_q <= '0; frac_q <= '0;
      lo_q <= '0; hi_q <= '0; t_q <= '0; prod_q <= '0; out_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        3'd0: if (start_i) begin
          neg_q <= p[48];
          mag_q <= p[48] ? 48'(-p) : p[47:0];
          st_q  <= 3'd1;
        end
        3'd1: begin
          top_q  <= (pos >> 16) >= 48'(TanhEntries);
          idx_q  <= pos[16 +: IdxW];
          frac_q <= pos[15:0];
          st_q   <= 3'd2;
        end
        3'd2: begin
          lo_q <= Rom[idx_q];
          hi_q <= Rom[IdxW'(idx_q) + (IdxW+1)'(1)];
          st_q <= 3'd3;
        end
        3'd3: begin
          prod_q <= 48'(((hi_q >= lo_q) ? hi_q - lo_q : '0)) * 48'(frac_q);
          st_q   <= 3'd4;
        end
        3'd4: begin
          t_q  <= top_q ? Rom[TanhEntries]
                        : bqpf_pkg::TabW'(48'(lo_q) + (prod_q >> 16));
          st_q <= 3'd5;
        end
        3'd5: begin
          out_q  <= neg_q ? -16'((scaled >> 30) > 48'd32767 ? 48'd32767 : scaled >> 30)
                          : 16'((scaled >> 30) > 48'd32767 ? 48'd32767 : scaled >> 30);
          done_q <= 1'b1;
          st_q   <= 3'd0;
        end
        default: st_q <= 3'd0;
      endcase
    end
  end

  assign out_o  = out_q;
  assign done_o = done_q;

endmodule

### rtl/biquad_cascade_phone_band_filter.sv
// top level of the phone band filter: apb registers, chain of five biquad cells, saturator
// depends on bqpf_pkg, bqpf_if, bqpf_cell, bqpf_sat
//
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    sample_in, buffer_start
//  out_ch    out   valid / ready    sample_out
//  apb       in    psel / penable   paddr, pwdata (64 bit), prdata
//
// a filtered item passes through each of the five cells (load, five macs, round and
// saturate, handoff), then the saturator, then the output register; the next item is
// taken once the result of the last one has moved into the output register
// bypassed items reach the output register in the accept cycle, one item per cycle while out_ch takes them
// a result that cannot leave waits in a holding register; input stalls until it moves
// buffer_start clears every cell history in the accept cycle
// reset clears registers to their defaults and all history

module biquad_cascade_phone_band_filter #(
  parameter int unsigned COEF_BITS    = 20,
  parameter int unsigned TANH_ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bqpf_in_if.sink                       in_ch,
  bqpf_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bqpf_pkg::AddrW-1:0]    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned Cb = COEF_BITS;
  localparam int unsigned N  = bqpf_pkg::NumCells;

  logic [59:0] hp_q, lp_q, pb_q;
  logic [39:0] pa_q;
  logic [15:0] gain_q;
  logic        bypass_q;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  // coefficient fields beyond bit 63 read as zero
  function automatic logic signed [Cb-1:0] field(input logic [63:0] r, input int k);
    if (k * Cb >= 64) return '0;
    return Cb'(r >> (k * Cb));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= '0; lp_q <= '0; pb_q <= '0; pa_q <= '0;
      gain_q <= 16'd25559; bypass_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (bqpf_pkg::reg_idx_e'(reg_idx))
        bqpf_pkg::REG_HP:     hp_q     <= pwdata[59:0];
        bqpf_pkg::REG_LP:     lp_q     <= pwdata[59:0];
        bqpf_pkg::REG_PEAK_B: pb_q     <= pwdata[59:0];
        bqpf_pkg::REG_PEAK_A: pa_q     <= pwdata[39:0];
        bqpf_pkg::REG_DRIVE:  gain_q   <= pwdata[15:0];
        bqpf_pkg::REG_BYPASS: bypass_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (bqpf_pkg::reg_idx_e'(reg_idx))
      bqpf_pkg::REG_HP:     prdata = 64'(hp_q);
      bqpf_pkg::REG_LP:     prdata = 64'(lp_q);
      bqpf_pkg::REG_PEAK_B: prdata = 64'(pb_q);
      bqpf_pkg::REG_PEAK_A: prdata = 64'(pa_q);
      bqpf_pkg::REG_DRIVE:  prdata = 64'(gain_q);
      bqpf_pkg::REG_BYPASS: prdata = 64'(bypass_q);
      default:              prdata = '0;
    endcase
  end

  // control
  logic        busy_q, busy_d;
  logic        ovalid_q, ovalid_d;
  logic        hold_q, hold_d;
  logic [15:0] odata_q, odata_d;
  logic [15:0] hdata_q, hdata_d;
  logic        accept;
  logic        clear;
  // busy from accept until the result has moved into the output register
  assign in_ch.ready = !busy_q;
  assign accept      = in_ch.valid && in_ch.ready;
  assign clear       = accept && in_ch.buffer_start;

  // chain of cells; each hands its output to the next when done
  logic signed [31:0]   cy   [N];
  logic                 cdn  [N];
  logic signed [31:0]   cx   [N];
  logic                 cstp [N];
  logic signed [Cb-1:0] hb0, ha1, ha2, lb0, la1, la2;

  assign hb0 = field(64'(hp_q), 0);
  assign ha1 = field(64'(hp_q), 1);
  assign ha2 = field(64'(hp_q), 2);
  assign lb0 = field(64'(lp_q), 0);
  assign la1 = field(64'(lp_q), 1);
  assign la2 = field(64'(lp_q), 2);

  for (genvar s = 0; s < N; s++) begin : g_cell
    bqpf_pkg::cell_ctrl_t ctl;
    logic signed [Cb-1:0] b0, b2, a1, a2;
    logic signed [Cb+1:0] b1;
    if (s == 0) begin : g_head
      assign cx[s]   = 32'(in_ch.sample_in) <<< 9;
      assign cstp[s] = accept && !bypass_q;
    end else begin : g_link
      assign cx[s]   = cy[s-1];
      assign cstp[s] = cdn[s-1];
    end
    if (s < 2) begin : g_hp
      assign b0 = hb0; assign b2 = hb0; assign a1 = ha1; assign a2 = ha2;
      assign b1 = -((Cb+2)'(hb0) <<< 1);
    end else if (s < 4) begin : g_lp
      assign b0 = lb0; assign b2 = lb0; assign a1 = la1; assign a2 = la2;
      assign b1 = (Cb+2)'(lb0) <<< 1;
    end else begin : g_pk
      assign b0 = field(64'(pb_q), 0); assign b2 = field(64'(pb_q), 2);
      assign b1 = (Cb+2)'(field(64'(pb_q), 1));
      assign a1 = field(64'(pa_q), 0); assign a2 = field(64'(pa_q), 1);
    end
    assign ctl.clear = clear;
    assign ctl.step  = cstp[s];
    bqpf_cell #(.CoefBits(Cb)) u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctl), .x_i(cx[s]),
      .b0_i(b0), .b1_i(b1), .b2_i(b2), .a1_i(a1), .a2_i(a2),
      .y_o(cy[s]), .done_o(cdn[s])
    );
  end

  logic signed [15:0] sat_out;
  logic               sat_done;
  bqpf_sat #(.TanhEntries(TANH_ENTRIES)) u_sat (
    .clk_i, .rst_ni, .start_i(cdn[N-1]), .y_i(cy[N-1]), .gain_i(gain_q),
    .out_o(sat_out), .done_o(sat_done)
  );

  // a result appears when a bypassed item is taken or the saturator finishes
  logic        res_v, out_free;
  logic [15:0] res_data;
  assign res_v    = (accept && bypass_q) || sat_done;
  assign res_data = sat_done ? sat_out : in_ch.sample_in;
  assign out_free = !ovalid_q || out_ch.ready;

  always_comb begin
    busy_d   = busy_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    hold_d   = hold_q;
    hdata_d  = hdata_q;
    if (ovalid_q && out_ch.ready) ovalid_d = 1'b0;
    if (accept) busy_d = 1'b1;
    if (hold_q && out_free) begin
      // parked result moves on, input opens again
      ovalid_d = 1'b1;
      odata_d  = hdata_q;
      hold_d   = 1'b0;
      busy_d   = 1'b0;
    end else if (res_v && out_free) begin
      ovalid_d = 1'b1;
      odata_d  = res_data;
      busy_d   = 1'b0;
    end else if (res_v) begin
      // output still taken by the previous item
      hold_d  = 1'b1;
      hdata_d = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; ovalid_q <= 1'b0; odata_q <= '0;
      hold_q <= 1'b0; hdata_q <= '0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      odata_q  <= odata_d;
      hold_q   <= hold_d;
      hdata_q  <= hdata_d;
    end
  end

  assign out_ch.valid      = ovalid_q;
  assign out_ch.sample_out = odata_q;

endmodule

### rtl/bqpf_checker.sv
// port level checks on the phone band filter
// depends on bqpf_if and the top level ports

module bqpf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_sample
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result dropped or changed");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown(out_sample))
    else $error("unknown result bits");

  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready, out_valid}))
    else $error("unknown handshake");

endmodule

bind biquad_cascade_phone_band_filter bqpf_checker u_bqpf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_sample(out_ch.sample_out)
);

### verif/biquad_cascade_phone_band_filter_tb.sv
// testbench for the phone band filter: apb setup, random pcm items, checked against a local predictor
// depends on bqpf_pkg, bqpf_if and the biquad_cascade_phone_band_filter rtl

module biquad_cascade_phone_band_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = 20;
  localparam int unsigned TE = 1024;
  localparam int unsigned FB = CB - 2;
  localparam longint LIMIT = 2_000_000;

  // filter model: coefficients, history and tanh table
  class pcm_scoreboard;
    logic [63:0] coef_reg[bqpf_pkg::NumRegs];
    logic signed [31:0] hist[20];
    longint unsigned tanh_tab[TE+1];
    logic signed [15:0] pending[$];
    int mism;

    function void clear_all();
      foreach (hist[i]) hist[i] = '0;
      foreach (coef_reg[i]) coef_reg[i] = '0;
      coef_reg[bqpf_pkg::REG_DRIVE] = 64'd25559;
      coef_reg[bqpf_pkg::REG_BYPASS] = 64'd1;
      mism = 0;
      pending.delete();
    endfunction

    function void build_tanh();
      longint unsigned h, term, r, e, den, num;
      h = (64'd16 << 31) / TE;
      term = 64'd1 << 31; r = term; e = term;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * h) >> 31) / n;
        if (n % 2) r -= term; else r += term;
      end
      for (int k = 0; k <= TE; k++) begin
        den = (64'd1 << 31) + e;
        num = ((64'd1 << 31) - e) << 30;
        tanh_tab[k] = (num + den / 2) / den;
        e = (e * r + (64'd1 << 30)) >> 31;
      end
    endfunction

    function longint field(logic [63:0] r, int k);
      logic [CB-1:0] raw;
      raw = r >> (k * CB);
      return longint'($signed(raw));
    endfunction

    function logic signed [31:0] stage(int s, logic signed [31:0] x, longint b0, longint b1,
                                       longint b2, longint a1, longint a2);
      longint acc;
      logic signed [31:0] y;
      acc = b0 * x + b1 * hist[4*s] + b2 * hist[4*s+1] - a1 * hist[4*s+2] - a2 * hist[4*s+3];
      acc = (acc + (64'sd1 <<< (FB - 1))) >>> FB;
      y = (acc > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
          (acc < -64'sh8000_0000) ? 32'sh8000_0000 : acc[31:0];
      hist[4*s+1] = hist[4*s]; hist[4*s] = x;
      hist[4*s+3] = hist[4*s+2]; hist[4*s+2] = y;
      return y;
    endfunction

    function logic signed [15:0] shape_tanh(logic signed [31:0] y);
      longint p;
      longint unsigned m, pos, idx, f, t, o, lo, hi;
      p = longint'(y) * longint'(coef_reg[bqpf_pkg::REG_DRIVE][15:0]);
      m = (p < 0) ? -p : p;
      pos = (m * TE) >> 23;
      idx = pos >> 16; f = pos & 64'hFFFF;
      if (idx >= TE) t = tanh_tab[TE];
      else begin
        lo = tanh_tab[idx]; hi = tanh_tab[idx+1];
        t = lo + ((((hi >= lo) ? hi - lo : 0) * f) >> 16);
      end
      o = (t * 32767 + (64'd1 << 29)) >> 30;
      if (o > 32767) o = 32767;
      return (p < 0) ? -16'(o) : 16'(o);
    endfunction

    // note one accepted item and queue its expected sample
    function void note_item(logic signed [15:0] s, logic start);
      logic signed [31:0] y;
      longint b0;
      logic [63:0] hp, lp, pb, pa;
      hp = coef_reg[bqpf_pkg::REG_HP];
      lp = coef_reg[bqpf_pkg::REG_LP];
      pb = coef_reg[bqpf_pkg::REG_PEAK_B];
      pa = coef_reg[bqpf_pkg::REG_PEAK_A];
      if (start) foreach (hist[i]) hist[i] = '0;
      if (coef_reg[bqpf_pkg::REG_BYPASS][0]) begin
        pending.push_back(s);
        return;
      end
      y = 32'(s) <<< 9;
      b0 = field(hp, 0);
      for (int s2 = 0; s2 < 2; s2++)
        y = stage(s2, y, b0, -2*b0, b0, field(hp, 1), field(hp, 2));
      b0 = field(lp, 0);
      for (int s2 = 2; s2 < 4; s2++)
        y = stage(s2, y, b0, 2*b0, b0, field(lp, 1), field(lp, 2));
      y = stage(4, y, field(pb, 0), field(pb, 1), field(pb, 2), field(pa, 0), field(pa, 1));
      pending.push_back(shape_tanh(y));
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected sample %0d", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mism++;
        if (mism <= 10) $display("sample mismatch: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bqpf_pkg::AddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  longint cycles = 0;

  bqpf_in_if in_ch ();
  bqpf_out_if out_ch ();
  pcm_scoreboard sb;

  biquad_cascade_phone_band_filter #(.COEF_BITS(CB), .TANH_ENTRIES(TE)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.buffer_start = 1'b0;
    out_ch.ready = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: stall pattern of its own, sometimes long open stretches
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) sb.check_sample(out_ch.sample_out);
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // apb write with setup and access phases; register i at byte 8*i since some are up to 60 bits wide
  task automatic reg_write(bqpf_pkg::reg_idx_e idx, logic [63:0] val);
    logic [63:0] masked;
    case (idx)
      bqpf_pkg::REG_HP, bqpf_pkg::REG_LP, bqpf_pkg::REG_PEAK_B:
        masked = val & 64'h0FFF_FFFF_FFFF_FFFF;
      bqpf_pkg::REG_PEAK_A: masked = val & 64'hFF_FFFF_FFFF;
      bqpf_pkg::REG_DRIVE: masked = val & 64'hFFFF;
      default: masked = val & 64'h1;
    endcase
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= bqpf_pkg::AddrW'(8 * int'(idx)); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.coef_reg[idx] = masked;
  endtask

  // one item, held until accepted; the caller follows with a new item or drops valid
  task automatic send_item(logic signed [15:0] s, logic start);
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    in_ch.buffer_start <= start;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(s, start);
  endtask

  task automatic send_burst(int n, bit mostly_small);
    int burst;
    logic signed [15:0] s;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        case ($urandom_range(0, 9))
          0: s = 16'sh7FFF;
          1: s = 16'sh8000;
          2, 3: s = 16'($urandom);
          default: s = mostly_small ? 16'($signed(11'($urandom))) : 16'($urandom);
        endcase
        send_item(s, ($urandom_range(0, 40) == 0));
      end
      if (n > 0 && $urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
      end
    end
  endtask

  // stop sending and wait until every item has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // q2.18 field packing helper
  function automatic logic [63:0] pack3(int c0, int c1, int c2);
    return {4'b0, 20'(c2), 20'(c1), 20'(c0)};
  endfunction

  initial begin
    sb = new();
    sb.clear_all();
    sb.build_tanh();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bypass after reset: extremes pass straight through
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh0000, 1'b0);
    send_item(-16'sd1, 1'b0);
    drain();

    // realistic 8 kHz phone band coefficients (approximate, q2.18)
    reg_write(bqpf_pkg::REG_HP, pack3(199_000, -398_000 + 0, 0) | pack3(0, -418_000, 151_000));
    reg_write(bqpf_pkg::REG_LP, pack3(40_000, -150_000, 60_000));
    reg_write(bqpf_pkg::REG_PEAK_B, pack3(270_000, -300_000, 200_000));
    reg_write(bqpf_pkg::REG_PEAK_A, pack3(-300_000, 208_000, 0));
    reg_write(bqpf_pkg::REG_BYPASS, 64'd0);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh1234, 1'b1);
    drain();

    // extremes: overflowing coefficients, full drive, and zero drive
    reg_write(bqpf_pkg::REG_HP, 64'h0FFF_FFFF_FFFF_FFFF);
    reg_write(bqpf_pkg::REG_LP, pack3(-524_288, 524_287, -524_288));
    reg_write(bqpf_pkg::REG_PEAK_B, pack3(524_287, 524_287, 524_287));
    reg_write(bqpf_pkg::REG_PEAK_A, pack3(-524_288, -524_288, 0));
    reg_write(bqpf_pkg::REG_DRIVE, 64'hFFFF);
    for (int i = 0; i < 8; i++) send_item(i[0] ? 16'sh7FFF : 16'sh8000, i == 0);
    drain();
    reg_write(bqpf_pkg::REG_DRIVE, 64'd0);
    send_item(16'sh7FFF, 1'b0);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0) begin
        reg_write(bqpf_pkg::REG_HP, {$urandom, $urandom});
        reg_write(bqpf_pkg::REG_LP, {$urandom, $urandom});
        reg_write(bqpf_pkg::REG_PEAK_B, {$urandom, $urandom});
        reg_write(bqpf_pkg::REG_PEAK_A, {$urandom, $urandom});
      end else begin
        reg_write(bqpf_pkg::REG_HP, pack3($urandom_range(150_000, 260_000),
                                          -$urandom_range(300_000, 500_000),
                                          $urandom_range(50_000, 200_000)));
        reg_write(bqpf_pkg::REG_LP, pack3($urandom_range(1_000, 60_000),
                                          -$urandom_range(100_000, 300_000),
                                          $urandom_range(30_000, 150_000)));
        reg_write(bqpf_pkg::REG_PEAK_B, pack3($urandom_range(200_000, 330_000),
                                              -$urandom_range(0, 400_000),
                                              $urandom_range(100_000, 260_000)));
        reg_write(bqpf_pkg::REG_PEAK_A, pack3(-$urandom_range(0, 400_000),
                                              $urandom_range(100_000, 250_000), 0));
      end
      reg_write(bqpf_pkg::REG_DRIVE, (ph == 4) ? 64'hFFFF : 64'($urandom_range(0, 65535)));
      reg_write(bqpf_pkg::REG_BYPASS, (ph == 7) ? 64'd1 : 64'd0);
      send_burst(163, ph % 2);
      drain();
    end

    if (sb.mism == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
